// File: rtl/nrfs_pkg.sv
`default_nettype none
package nrfs_pkg;

  // Fixed sentence geometry
  localparam int unsigned HeaderLen      = 6;
  localparam int unsigned PositionLimit  = 100;
  localparam int unsigned SegmentLimit   = 10;
  localparam int unsigned FieldMaxCharsDef = 16;
  localparam int unsigned QueueDepthDef  = 4;

  localparam logic [7:0] ASCII_COMMA = 8'h2C;

  // Final status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_COMMA   = 2'd1;
  localparam logic [1:0] ST_BAD_HEADER = 2'd2;
  localparam logic [1:0] ST_TOO_FEW    = 2'd3;

  // One result item as it travels from front to back
  typedef struct packed {
    logic       is_status;
    logic [3:0] field_number;
    logic [3:0] char_position;
    logic [7:0] field_char;
    logic [1:0] parse_status;
  } rmc_result_t;

  // Expected header text, one byte per position
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24; // $
      3'd1:    ch = 8'h47; // G
      3'd2:    ch = 8'h50; // P
      3'd3:    ch = 8'h52; // R
      3'd4:    ch = 8'h4D; // M
      3'd5:    ch = 8'h43; // C
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: rtl/nrfs_front.sv
`default_nettype none
module nrfs_front #(
  parameter int unsigned FIELD_MAX_CHARS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic [7:0]         in_char,
  input  wire logic               end_of_text,
  output      logic               res_push,
  output      nrfs_pkg::rmc_result_t res_data
);
  import nrfs_pkg::*;

  localparam logic [6:0] MaxChars = 7'(FIELD_MAX_CHARS);
  localparam logic [6:0] HdrLen   = 7'(HeaderLen);
  localparam logic [6:0] PosLim   = 7'(PositionLimit);
  localparam logic [3:0] SegLim   = 4'(SegmentLimit);

  logic [3:0] seg_cnt_r, seg_cnt_nxt;
  logic [6:0] seg_pos_r, seg_pos_nxt;
  logic       hdr_match_r, hdr_match_nxt;
  logic       hdr_checked_r, hdr_checked_nxt;
  logic       is_comma;
  logic       one_letter;
  logic       keep;
  logic [1:0] status;

  assign is_comma   = (in_char == ASCII_COMMA);
  assign one_letter = (seg_cnt_r == 4'd2) || (seg_cnt_r == 4'd4) || (seg_cnt_r == 4'd6);
  assign keep       = one_letter ? (seg_pos_r == 7'd0) : (seg_pos_r < MaxChars);

  // Segment tracking, field character selection and final status
  always_comb begin
    seg_cnt_nxt     = seg_cnt_r;
    seg_pos_nxt     = seg_pos_r;
    hdr_match_nxt   = hdr_match_r;
    hdr_checked_nxt = hdr_checked_r;
    res_push        = 1'b0;
    res_data        = '0;
    status          = ST_OK;
    if (in_fire) begin
      if (is_comma) begin
        if (seg_cnt_r == 4'd0) begin
          hdr_match_nxt   = hdr_match_r && (seg_pos_r == HdrLen);
          hdr_checked_nxt = 1'b1;
        end
        if (seg_cnt_r < SegLim) begin
          seg_cnt_nxt = seg_cnt_r + 4'd1;
        end
        seg_pos_nxt = 7'd0;
      end else begin
        if (seg_cnt_r == 4'd0) begin
          if ((seg_pos_r >= HdrLen) || (in_char != header_char(seg_pos_r[2:0]))) begin
            hdr_match_nxt = 1'b0;
          end
        end else if ((seg_cnt_r < SegLim) && !end_of_text && keep) begin
          res_push               = 1'b1;
          res_data.field_number  = seg_cnt_r;
          res_data.char_position = seg_pos_r[3:0];
          res_data.field_char    = in_char;
        end
        if (seg_pos_r < PosLim) begin
          seg_pos_nxt = seg_pos_r + 7'd1;
        end
      end
      if (end_of_text) begin
        if (seg_cnt_nxt == 4'd0) begin
          status = ST_NO_COMMA;
        end else if (!(hdr_checked_nxt && hdr_match_nxt)) begin
          status = ST_BAD_HEADER;
        end else if (seg_cnt_nxt < SegLim) begin
          status = ST_TOO_FEW;
        end else begin
          status = ST_OK;
        end
        res_push              = 1'b1;
        res_data              = '0;
        res_data.is_status    = 1'b1;
        res_data.parse_status = status;
        seg_cnt_nxt           = 4'd0;
        seg_pos_nxt           = 7'd0;
        hdr_match_nxt         = 1'b1;
        hdr_checked_nxt       = 1'b0;
      end
    end
  end

  // Sentence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r     <= 4'd0;
      seg_pos_r     <= 7'd0;
      hdr_match_r   <= 1'b1;
      hdr_checked_r <= 1'b0;
    end else begin
      seg_cnt_r     <= seg_cnt_nxt;
      seg_pos_r     <= seg_pos_nxt;
      hdr_match_r   <= hdr_match_nxt;
      hdr_checked_r <= hdr_checked_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/nrfs_queue.sv
`default_nettype none
module nrfs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire nrfs_pkg::rmc_result_t push_data,
  input  wire logic                  pop,
  output      logic                  not_empty,
  output      logic                  not_full,
  output      nrfs_pkg::rmc_result_t pop_data
);
  import nrfs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  rmc_result_t         slot_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != Full);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slot_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/nrfs_back.sv
`default_nettype none
module nrfs_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire nrfs_pkg::rmc_result_t q_data,
  output      logic                  q_pop,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [23:0]           out_tdata,
  output      logic                  out_tuser
);
  import nrfs_pkg::*;

  logic        valid_r, valid_nxt;
  rmc_result_t data_r;
  logic        load;

  // Output register refills whenever it is empty or being drained
  assign load      = q_valid && (!valid_r || out_tready);
  assign q_pop     = load;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= q_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = data_r.is_status;
  assign out_tdata  = {6'd0, data_r.parse_status, data_r.field_char,
                       data_r.char_position, data_r.field_number};

endmodule
`default_nettype wire

// File: rtl/nmea_rmc_field_splitter.sv
`default_nettype none
// Channel  Dir  tdata (low bit up)                                  tuser / tlast
// in_      in   [7:0] in_char                                       tlast: end_of_text
// out_     out  [3:0] field_number [7:4] char_position              tuser: is_status
//               [15:8] field_char [17:16] parse_status [23:18] zero
//
// One character is taken per cycle while in_tready is high; the sentence state updates in the same cycle.
// A result passes from the front through the queue and then the output register
// before it reaches out_. in_tready drops only when the queue is full.
// Synchronous active-low reset clears the sentence state, queue and output valid.
module nmea_rmc_field_splitter #(
  parameter int unsigned FIELD_MAX_CHARS = nrfs_pkg::FieldMaxCharsDef,
  parameter int unsigned QUEUE_DEPTH     = nrfs_pkg::QueueDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_char
  input  wire logic        in_tlast,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // field_number, char_position, field_char, parse_status
  output      logic        out_tuser   // is_status
);
  import nrfs_pkg::*;

  logic        in_fire;
  logic        res_push;
  rmc_result_t res_data;
  logic        q_valid;
  logic        q_pop;
  rmc_result_t q_data;

  assign in_fire = in_tvalid && in_tready;

  // Front: segment tracking and classification
  nrfs_front #(
    .FIELD_MAX_CHARS(FIELD_MAX_CHARS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_char    (in_tdata),
    .end_of_text(in_tlast),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  // Decoupling queue
  nrfs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .pop      (q_pop),
    .not_empty(q_valid),
    .not_full (in_tready),
    .pop_data (q_data)
  );

  // Back: output register
  nrfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

// File: bench/tb_nmea_rmc_field_splitter.sv
`timescale 1ns / 1ps

module tb_nmea_rmc_field_splitter;
  import nrfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [47:0] RMC_TAG     = "$GPRMC";
  localparam int unsigned MAX_PRINTS  = 40;

  // Sentence tracker: mirrors the splitter and queues the results it owes
  class rmc_scoreboard;
    logic [3:0]  seg_count;
    logic [6:0]  seg_pos;
    bit          hdr_match;
    bit          hdr_checked;
    rmc_result_t owed_q[$];
    int          errors;
    int          field_hits;
    int          status_hits[4];

    function new();
      clear_sentence();
      errors = 0;
      field_hits = 0;
      status_hits = '{0, 0, 0, 0};
    endfunction

    function void clear_sentence();
      seg_count   = '0;
      seg_pos     = '0;
      hdr_match   = 1'b1;
      hdr_checked = 1'b0;
    endfunction

    // Called for every accepted input transfer
    function void note_char(input logic [7:0] c, input logic eot);
      rmc_result_t r;
      bit          keep;
      if (c == ASCII_COMMA) begin
        if (seg_count == 0) begin
          hdr_match   = hdr_match && (seg_pos == HeaderLen);
          hdr_checked = 1'b1;
        end
        if (seg_count < SegmentLimit) seg_count++;
        seg_pos = '0;
      end else begin
        if (seg_count == 0) begin
          if (seg_pos >= HeaderLen || c != RMC_TAG[47 - 8 * seg_pos -: 8]) hdr_match = 1'b0;
        end else if (seg_count < SegmentLimit && !eot) begin
          // status and hemisphere segments carry a single letter
          keep = (seg_count inside {4'd2, 4'd4, 4'd6}) ? (seg_pos == 0)
                                                       : (seg_pos < FieldMaxCharsDef);
          if (keep) begin
            r = '0;
            r.field_number  = seg_count;
            r.char_position = seg_pos[3:0];
            r.field_char    = c;
            owed_q.push_back(r);
          end
        end
        if (seg_pos < PositionLimit) seg_pos++;
      end

      // final character: status by priority, then back to a fresh sentence
      if (eot) begin
        r = '0;
        r.is_status = 1'b1;
        if (seg_count == 0)                   r.parse_status = ST_NO_COMMA;
        else if (!(hdr_checked && hdr_match)) r.parse_status = ST_BAD_HEADER;
        else if (seg_count < SegmentLimit)    r.parse_status = ST_TOO_FEW;
        else                                  r.parse_status = ST_OK;
        owed_q.push_back(r);
        clear_sentence();
      end
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Called for every accepted output transfer
    task check_result(input logic [23:0] d, input logic u);
      rmc_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tuser=%b", d, u));
        return;
      end
      want = owed_q.pop_front();
      if (u !== want.is_status)
        report_mismatch($sformatf("is_status %b, want %b", u, want.is_status));
      if (d[3:0] !== want.field_number)
        report_mismatch($sformatf("field_number %0d, want %0d", d[3:0], want.field_number));
      if (d[7:4] !== want.char_position)
        report_mismatch($sformatf("char_position %0d, want %0d", d[7:4], want.char_position));
      if (d[15:8] !== want.field_char)
        report_mismatch($sformatf("field_char %h, want %h", d[15:8], want.field_char));
      if (d[17:16] !== want.parse_status)
        report_mismatch($sformatf("parse_status %0d, want %0d", d[17:16], want.parse_status));
      if (d[23:18] !== 6'd0)
        report_mismatch($sformatf("tdata pad bits %b, want zero", d[23:18]));
      if (want.is_status) status_hits[want.parse_status]++;
      else field_hits++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_char
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [3:0] field_number [7:4] char_position [15:8] field_char
                           // [17:16] parse_status
  logic        out_tuser;  // is_status

  rmc_scoreboard sb;
  logic [7:0]    text_q[$];
  int unsigned   burst_left;
  int unsigned   items_sent;
  int unsigned   n_sentences;
  int unsigned   cycles;
  int unsigned   stall_tick;
  int unsigned   stall_mode;

  nmea_rmc_field_splitter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_nmea_rmc_field_splitter NOT OK");
      $finish;
    end
  end

  // Receiver: check transfers; the backpressure mode is redrawn at random whenever stall_tick[7:0] wraps to zero
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    stall_tick++;
    if (stall_tick[7:0] == 8'd0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= (stall_tick % 4 != 0);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Sender: bursts of random length separated by short gaps
  task automatic send_char(input logic [7:0] c, input logic eot);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 250)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(c, eot);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eot_last && (i == s.len() - 1));
    n_sentences++;
  endtask

  function automatic logic [7:0] non_comma_byte();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (b == ASCII_COMMA);
    return b;
  endfunction

  // Segment length: mostly short, sometimes past the field limit or position cap
  function automatic int unsigned field_len(input int unsigned seg);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (seg == 2 || seg == 4 || seg == 6)
      return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
    if (r < 80) return $urandom_range(0, 5);
    if (r < 96) return $urandom_range(6, 20);
    return $urandom_range(21, 110);
  endfunction

  // Random sentence: mostly well formed, some with broken header, wrong comma
  // count, or pure noise
  task automatic build_sentence();
    int unsigned kind;
    int unsigned roll;
    int unsigned n_commas;
    int unsigned cut;
    int unsigned comma_pct;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      comma_pct = ($urandom_range(0, 1) == 0) ? 0 : 20;
      repeat ($urandom_range(1, 30))
        text_q.push_back(($urandom_range(0, 99) < comma_pct) ? ASCII_COMMA : non_comma_byte());
    end else begin
      for (int i = 0; i < HeaderLen; i++) text_q.push_back(RMC_TAG[47 - 8 * i -: 8]);
      if (kind < 25) begin
        case ($urandom_range(0, 2))
          0: text_q[$urandom_range(0, HeaderLen - 1)] = non_comma_byte();
          1: begin
            cut = $urandom_range(0, HeaderLen - 1);
            while (text_q.size() > cut) void'(text_q.pop_back());
          end
          default: repeat ($urandom_range(1, 110)) text_q.push_back(non_comma_byte());
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 15)      n_commas = $urandom_range(0, 9);
      else if (roll < 25) n_commas = $urandom_range(11, 14);
      else                n_commas = SegmentLimit;
      for (int unsigned seg = 1; seg <= n_commas; seg++) begin
        text_q.push_back(ASCII_COMMA);
        if (seg < SegmentLimit) repeat (field_len(seg)) text_q.push_back(non_comma_byte());
        else repeat ($urandom_range(0, 4)) text_q.push_back(non_comma_byte());
      end
    end
    if (text_q.size() == 0) text_q.push_back(non_comma_byte());
  endtask

  initial begin
    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    burst_left  = 0;
    items_sent  = 0;
    n_sentences = 0;
    cycles      = 0;
    stall_tick  = 0;
    stall_mode  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero byte alone, comma then 0xFF, last item on a comma,
    // last item on a field letter, minimal complete sentence
    send_char(8'h00, 1'b1);
    n_sentences++;
    send_char(ASCII_COMMA, 1'b0);
    send_char(8'hFF, 1'b1);
    n_sentences++;
    send_text("$GPRMC,,", 1'b1);
    send_text("$GPRMC,A", 1'b1);
    send_text("$GPRMC,,,,,,,,,,", 1'b1);

    // Random sentences
    while (items_sent < 1200) begin
      build_sentence();
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
      n_sentences++;
    end
    in_tvalid <= 1'b0;

    // Drain, then give the output pipe time to show any extra result
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d sentences, %0d characters, %0d field characters checked",
             n_sentences, items_sent, sb.field_hits);
    $display("statuses ok %0d, no comma %0d, bad header %0d, too few %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_NO_COMMA],
             sb.status_hits[ST_BAD_HEADER], sb.status_hits[ST_TOO_FEW]);
    if (sb.errors == 0) begin
      $display("tb_nmea_rmc_field_splitter OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_nmea_rmc_field_splitter NOT OK");
    end
    $finish;
  end

endmodule
